FILE: rtl/qbvs_pkg.sv
// Shared types, constants and the vertex builder for the quad batch vertex setup block.
// Holds the stream word layouts and the slot lookup interface; depends on nothing.
package qbvs_pkg;

   localparam int MAX_SLOTS  = 32;
   localparam int MAX_QUADS  = 8192;
   localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
   localparam int USED_W     = $clog2(MAX_SLOTS + 1);
   localparam int QUAD_CNT_W = $clog2(MAX_QUADS + 1);
   localparam int TEX_ID_W   = 16;
   localparam int IDX_CNT_W  = 16;
   localparam int TEX_SLOT_W = 5;

   localparam int REQ_DATA_W = 256;
   localparam int RSP_DATA_W = 176;

   // Operation codes on the request tuser bit
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_QUAD  = 1'b1;

   // Corner codes, emitted in this order
   localparam logic [1:0] CORNER_BL = 2'd0;
   localparam logic [1:0] CORNER_BR = 2'd1;
   localparam logic [1:0] CORNER_TR = 2'd2;
   localparam logic [1:0] CORNER_TL = 2'd3;

   localparam logic [31:0] WHITE_RGBA = 32'hFFFF_FFFF;

   // Request word, first field in the lowest bits
   typedef struct packed {
      logic [15:0] uv_scale_v;
      logic [15:0] uv_scale_u;
      logic [15:0] uv_off_v;
      logic [15:0] uv_off_u;
      logic [15:0] texture_id;
      logic [31:0] rgba;
      logic [30:0] size_y;
      logic [30:0] size_x;
      logic [17:0] pos_z;
      logic [31:0] pos_y;
      logic [31:0] pos_x;
   } req_word_type;

   // Response word, first field in the lowest bits, zero padded on top
   typedef struct packed {
      logic [2:0]             pad;
      logic [IDX_CNT_W-1:0]   index_count;
      logic                   batch_full;
      logic                   slot_overflow;
      logic [1:0]             corner;
      logic [TEX_SLOT_W-1:0]  tex_slot;
      logic [31:0]            vertex_rgba;
      logic [16:0]            tex_v;
      logic [16:0]            tex_u;
      logic [17:0]            vz;
      logic [31:0]            vy;
      logic [31:0]            vx;
   } rsp_word_type;

   // Everything held for one quad while its corners go out
   typedef struct packed {
      logic [31:0]           pos_x;
      logic [31:0]           pos_y;
      logic [17:0]           pos_z;
      logic [30:0]           size_x;
      logic [30:0]           size_y;
      logic [15:0]           uv_off_u;
      logic [15:0]           uv_off_v;
      logic [15:0]           uv_scale_u;
      logic [15:0]           uv_scale_v;
      logic [31:0]           colour;
      logic [TEX_SLOT_W-1:0] slot;
      logic                  overflow;
      logic                  full;
      logic [IDX_CNT_W-1:0]  index_count;
   } quad_type;

   // Lookup request into the slot chain
   typedef struct packed {
      logic                start;
      logic                lookup;
      logic [TEX_ID_W-1:0] id;
   } slot_req_type;

   // Lookup answer from the slot chain
   typedef struct packed {
      logic [SLOT_IDX_W-1:0] slot;
      logic                  overflow;
   } slot_rsp_type;

   // Build one corner vertex of a held quad
   function automatic rsp_word_type make_vertex(quad_type q, logic [1:0] c);
      rsp_word_type w;
      logic         right;
      logic         top;
      right           = (c == CORNER_BR) || (c == CORNER_TR);
      top             = (c == CORNER_TR) || (c == CORNER_TL);
      w               = '0;
      w.vx            = q.pos_x + (right ? {1'b0, q.size_x} : 32'd0);
      w.vy            = q.pos_y + (top ? {1'b0, q.size_y} : 32'd0);
      w.vz            = q.pos_z;
      w.tex_u         = {1'b0, q.uv_off_u} + (right ? {1'b0, q.uv_scale_u} : 17'd0);
      w.tex_v         = {1'b0, q.uv_off_v} + (top ? {1'b0, q.uv_scale_v} : 17'd0);
      w.vertex_rgba   = q.colour;
      w.tex_slot      = q.slot;
      w.corner        = c;
      w.slot_overflow = q.overflow;
      w.batch_full    = q.full;
      w.index_count   = q.index_count;
      return w;
   endfunction

endpackage

FILE: rtl/qbvs_slot_cell.sv
// One texture slot: holds a texture id, matches it against the query and passes the
// match on to its neighbour. Depends on qbvs_pkg.
module qbvs_slot_cell (
   input  logic                           clock,
   input  logic [qbvs_pkg::SLOT_IDX_W-1:0] index,
   input  logic [qbvs_pkg::USED_W-1:0]     used,
   input  logic [qbvs_pkg::TEX_ID_W-1:0]   id,
   input  logic                           claim,
   input  logic                           hit_in,
   input  logic [qbvs_pkg::SLOT_IDX_W-1:0] slot_in,
   output logic                           hit_out,
   output logic [qbvs_pkg::SLOT_IDX_W-1:0] slot_out
);
   import qbvs_pkg::*;

   logic [TEX_ID_W-1:0] entry_ff;
   logic                live;
   logic                hit_here;
   logic                load;

   // Slot zero holds the white texture and never matches a nonzero id
   assign live     = (index != '0) && ({1'b0, index} < used);
   assign hit_here = live && (entry_ff == id);
   assign hit_out  = hit_in | hit_here;
   assign slot_out = slot_in | (hit_here ? index : '0);

   // Take the id when this is the next free slot
   assign load = claim && ({1'b0, index} == used);

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= id;
      end
   end

endmodule

FILE: rtl/qbvs_slot_chain.sv
// Row of texture slot cells with the used-slot count; answers a lookup and claims a
// free slot on a miss. Depends on qbvs_pkg and qbvs_slot_cell.
module qbvs_slot_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  qbvs_pkg::slot_req_type req,
   output qbvs_pkg::slot_rsp_type rsp
);
   import qbvs_pkg::*;

   logic [USED_W-1:0]     used_ff;
   logic [USED_W-1:0]     used_in;
   logic [MAX_SLOTS:0]    hit_chain;
   logic [SLOT_IDX_W-1:0] slot_chain [MAX_SLOTS+1];
   logic                  miss;
   logic                  room;
   logic                  claim;

   assign hit_chain[0]  = 1'b0;
   assign slot_chain[0] = '0;

   // Chain the cells: the match and its slot ripple along the row
   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      qbvs_slot_cell u_cell (
         .clock    (clock),
         .index    (SLOT_IDX_W'(i)),
         .used     (used_ff),
         .id       (req.id),
         .claim    (claim),
         .hit_in   (hit_chain[i]),
         .slot_in  (slot_chain[i]),
         .hit_out  (hit_chain[i+1]),
         .slot_out (slot_chain[i+1])
      );
   end

   assign miss  = req.lookup && !hit_chain[MAX_SLOTS];
   assign room  = used_ff < USED_W'(MAX_SLOTS);
   assign claim = miss && room;

   // Answer the lookup: hit, fresh claim or overflow to slot zero
   always_comb begin
      rsp = '0;
      if (req.lookup) begin
         if (hit_chain[MAX_SLOTS]) begin
            rsp.slot = slot_chain[MAX_SLOTS];
         end else if (room) begin
            rsp.slot = used_ff[SLOT_IDX_W-1:0];
         end else begin
            rsp.overflow = 1'b1;
         end
      end
   end

   // Advance the used count on a claim, drop back to the white slot on a new batch
   always_comb begin
      used_in = used_ff;
      if (req.start) begin
         used_in = USED_W'(1);
      end else if (claim) begin
         used_in = used_ff + USED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= USED_W'(1);
      end else begin
         used_ff <= used_in;
      end
   end

endmodule

FILE: rtl/quad_batch_vertex_setup.sv
// Quad batch vertex setup: a quad word gives four vertex words, a begin word gives none.
// The first vertex is valid in the cycle after the quad word is taken.
// Each quad leaves as four vertex words on the single output; a new word is taken in the
// cycle the fourth vertex leaves, or whenever no vertex is pending.
// Reset (synchronous, active high): slot table holds only the white texture, quad count 0.
// Depends on qbvs_pkg and qbvs_slot_chain.
module quad_batch_vertex_setup (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pos_x, pos_y, pos_z, size_x, size_y, rgba, texture_id,
   // uv_off_u, uv_off_v, uv_scale_u, uv_scale_v
   input  logic [qbvs_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // vx, vy, vz, tex_u, tex_v, vertex_rgba, tex_slot, corner,
   // slot_overflow, batch_full, index_count, zero pad
   output logic [qbvs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import qbvs_pkg::*;

   req_word_type          req_word;
   slot_req_type          slot_req;
   slot_rsp_type          slot_rsp;
   quad_type              quad_ff;
   quad_type              quad_in;
   rsp_word_type          word_ff;
   logic                  valid_ff;
   logic [1:0]            corner_ff;
   logic [QUAD_CNT_W-1:0] quads_ff;
   logic [QUAD_CNT_W-1:0] quads_in;
   logic [IDX_CNT_W-1:0]  quads_wide;
   logic                  full;
   logic                  take;
   logic                  accept;
   logic                  end_quad;
   logic [1:0]            corner_next;

   assign req_word = req_word_type'(req_tdata);

   // Handshakes: take a new word when no vertex is pending or as the fourth vertex leaves
   assign take       = valid_ff && rsp_tready;
   assign end_quad   = take && (corner_ff == CORNER_TL);
   assign req_tready = !valid_ff || end_quad;
   assign accept     = req_tvalid && req_tready;

   // Slot lookup for textured quads
   assign slot_req.start  = accept && (req_tuser == OP_BEGIN);
   assign slot_req.lookup = accept && (req_tuser == OP_QUAD) && (req_word.texture_id != '0);
   assign slot_req.id     = req_word.texture_id;

   qbvs_slot_chain u_chain (
      .clock (clock),
      .reset (reset),
      .req   (slot_req),
      .rsp   (slot_rsp)
   );

   // Quad count, held once the batch is full
   assign full       = quads_ff >= QUAD_CNT_W'(MAX_QUADS);
   assign quads_in   = full ? quads_ff : quads_ff + QUAD_CNT_W'(1);
   assign quads_wide = IDX_CNT_W'(quads_in);

   // Gather the quad as accepted
   always_comb begin
      quad_in             = '0;
      quad_in.pos_x       = req_word.pos_x;
      quad_in.pos_y       = req_word.pos_y;
      quad_in.pos_z       = req_word.pos_z;
      quad_in.size_x      = req_word.size_x;
      quad_in.size_y      = req_word.size_y;
      quad_in.uv_off_u    = req_word.uv_off_u;
      quad_in.uv_off_v    = req_word.uv_off_v;
      quad_in.uv_scale_u  = req_word.uv_scale_u;
      quad_in.uv_scale_v  = req_word.uv_scale_v;
      quad_in.colour      = (req_word.texture_id == '0) ? req_word.rgba : WHITE_RGBA;
      quad_in.slot        = TEX_SLOT_W'(slot_rsp.slot);
      quad_in.overflow    = slot_rsp.overflow;
      quad_in.full        = full;
      quad_in.index_count = (quads_wide << 2) + (quads_wide << 1);
   end

   assign corner_next = corner_ff + 2'd1;

   // Control: output valid, corner counter and quad count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         corner_ff <= CORNER_BL;
         quads_ff  <= '0;
      end else begin
         if (accept && (req_tuser == OP_QUAD)) begin
            valid_ff  <= 1'b1;
            corner_ff <= CORNER_BL;
         end else if (take) begin
            if (corner_ff == CORNER_TL) begin
               valid_ff <= 1'b0;
            end else begin
               corner_ff <= corner_next;
            end
         end
         if (accept) begin
            case (req_tuser)
               OP_BEGIN: begin
                  quads_ff <= '0;
               end
               OP_QUAD: begin
                  quads_ff <= quads_in;
               end
               default: begin
                  quads_ff <= quads_ff;
               end
            endcase
         end
      end
   end

   // Payload: hold the quad and load each vertex word in turn
   always_ff @(posedge clock) begin
      if (accept && (req_tuser == OP_QUAD)) begin
         quad_ff <= quad_in;
         word_ff <= make_vertex(quad_in, CORNER_BL);
      end else if (take && (corner_ff != CORNER_TL)) begin
         word_ff <= make_vertex(quad_ff, corner_next);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(word_ff);
   assign rsp_tlast  = (corner_ff == CORNER_TL);

endmodule
